[design/dsms_pkg.sv]
// Shared types, register indexes and coil tables for the dual stepper sequencer.
`default_nettype none
package dsms_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_Y_STEPS_PER_REV = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_X_STEPS_PER_REV = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_Y_STEP_DELAY    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_X_STEP_DELAY    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FOUR_WIRE       = 3'd4;

  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [14:0] REMAIN_MAX  = 15'h7FFF;
  localparam logic [15:0] MOVE_MOST_NEG = 16'h8000;

  // Per-item commands from the top level to one motor.
  typedef struct packed {
    logic tick;
    logic load;
  } motor_ctrl_t;

  // Status of one motor for the item under work.
  typedef struct packed {
    logic active;       // steps remain before this item
    logic stepped;      // a step is taken on this item
    logic active_next;  // steps remain after this item
  } motor_status_t;

  function automatic logic [3:0] coil_pattern(input logic four, input logic [1:0] phase);
    logic [3:0] pat;
    if (four) begin
      unique case (phase)
        2'd0: pat = 4'h5;
        2'd1: pat = 4'h6;
        2'd2: pat = 4'hA;
        2'd3: pat = 4'h9;
      endcase
    end else begin
      unique case (phase)
        2'd0: pat = 4'h2;
        2'd1: pat = 4'h3;
        2'd2: pat = 4'h1;
        2'd3: pat = 4'h0;
      endcase
    end
    return pat;
  endfunction

endpackage
`default_nettype wire

[design/dual_stepper_move_sequencer_unit.sv]
// Top level of the dual stepper move sequencer with configuration registers.
`default_nettype none
// Sequencer for two full-step stepper motors, Y and X. Each input transfer is
// either a move command (cmd = 0) carrying signed step counts, or a one
// millisecond tick (cmd = 1). Every input produces exactly one result with the
// coil levels, step flags, positions and busy/refused status. An input lands in
// an input register; the motor update runs combinationally from there into the
// output register, so one item is accepted per cycle while the output is not
// stalled, and the result is registered in the output register behind the input
// register. While a result waits, one more item can be taken into the input
// register; after that the input stalls until the waiting result is transferred.
// Registers are written through the configuration channel, which is always
// ready; write them only while no item is in flight.
module dual_stepper_move_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic signed [15:0] y_move,
  input  wire logic signed [15:0] x_move,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       y_coils,
  output logic [3:0]       x_coils,
  output logic             y_stepped,
  output logic             x_stepped,
  output logic [15:0]      y_pos,
  output logic [15:0]      x_pos,
  output logic             busy_res,
  output logic             move_refused
);
  import dsms_pkg::*;

  logic [15:0] y_steps_per_rev;
  logic [15:0] x_steps_per_rev;
  logic [15:0] y_step_delay;
  logic [15:0] x_step_delay;
  logic        four_wire;

  logic        s1_valid;
  logic        s1_cmd;
  logic [15:0] s1_y_move;
  logic [15:0] s1_x_move;

  logic          advance;
  logic          busy;
  logic          refused;
  motor_ctrl_t   ctrl;
  motor_status_t y_status;
  motor_status_t x_status;
  logic [15:0]   y_pos_next;
  logic [15:0]   x_pos_next;
  logic [3:0]    y_coils_next;
  logic [3:0]    x_coils_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      y_steps_per_rev <= 16'd200;
      x_steps_per_rev <= 16'd200;
      y_step_delay    <= 16'd100;
      x_step_delay    <= 16'd100;
      four_wire       <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_Y_STEPS_PER_REV: y_steps_per_rev <= cfg_data;
        CFG_X_STEPS_PER_REV: x_steps_per_rev <= cfg_data;
        CFG_Y_STEP_DELAY:    y_step_delay    <= cfg_data;
        CFG_X_STEP_DELAY:    x_step_delay    <= cfg_data;
        CFG_FOUR_WIRE:       four_wire       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd    <= cmd;
      s1_y_move <= y_move;
      s1_x_move <= x_move;
    end
  end

  // A move is taken only when neither motor has steps left.
  always_comb begin
    busy      = y_status.active || x_status.active;
    refused   = (s1_cmd == CMD_MOVE) && busy;
    ctrl.tick = (s1_cmd == CMD_TICK);
    ctrl.load = (s1_cmd == CMD_MOVE) && !busy;
  end

  dsms_motor u_motor_y (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .ctrl          (ctrl),
    .move_val      (s1_y_move),
    .steps_per_rev (y_steps_per_rev),
    .step_delay    (y_step_delay),
    .four_wire     (four_wire),
    .status        (y_status),
    .position_next (y_pos_next),
    .coils_next    (y_coils_next)
  );

  dsms_motor u_motor_x (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .ctrl          (ctrl),
    .move_val      (s1_x_move),
    .steps_per_rev (x_steps_per_rev),
    .step_delay    (x_step_delay),
    .four_wire     (four_wire),
    .status        (x_status),
    .position_next (x_pos_next),
    .coils_next    (x_coils_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      y_coils      <= y_coils_next;
      x_coils      <= x_coils_next;
      y_stepped    <= y_status.stepped;
      x_stepped    <= x_status.stepped;
      y_pos        <= y_pos_next;
      x_pos        <= x_pos_next;
      busy_res     <= y_status.active_next || x_status.active_next;
      move_refused <= refused;
    end
  end

`ifndef SYNTHESIS
  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input register empty but input not ready");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("item left the input register without a result");

  a_refused_no_load: assert property (@(posedge clk) disable iff (rst)
    s1_valid && refused |-> !ctrl.load)
    else $error("refused move still loaded a motor");

  a_two_wire_y: assert property (@(posedge clk) disable iff (rst)
    out_valid && y_stepped && !four_wire |-> y_coils[3:2] == 2'b00)
    else $error("two-wire Y step drove upper coil bits");

  a_two_wire_x: assert property (@(posedge clk) disable iff (rst)
    out_valid && x_stepped && !four_wire |-> x_coils[3:2] == 2'b00)
    else $error("two-wire X step drove upper coil bits");
`endif

endmodule
`default_nettype wire

[design/dsms_motor.sv]
// State and step logic of one stepper motor.
`default_nettype none
module dsms_motor (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire dsms_pkg::motor_ctrl_t ctrl,
  input  wire logic [15:0]           move_val,
  input  wire logic [15:0]           steps_per_rev,
  input  wire logic [15:0]           step_delay,
  input  wire logic                  four_wire,
  output dsms_pkg::motor_status_t    status,
  output logic [15:0]                position_next,
  output logic [3:0]                 coils_next
);
  import dsms_pkg::*;

  logic [15:0] position;
  logic        forward;
  logic [14:0] remaining;
  logic [15:0] elapsed;
  logic [3:0]  coil_state;

  logic [15:0] elapsed_t;
  logic [15:0] neg_val;
  logic [14:0] rem_l;
  logic        fwd_l;
  logic [15:0] n;
  logic        step;
  logic [15:0] pos_step;
  logic [16:0] pos_inc;
  logic        forward_next;
  logic [14:0] remaining_next;
  logic [15:0] elapsed_next;

  always_comb begin
    elapsed_t = (ctrl.tick && elapsed != ELAPSED_MAX) ? elapsed + 16'd1 : elapsed;

    neg_val = 16'd0 - move_val;
    rem_l   = remaining;
    fwd_l   = forward;
    if (ctrl.load) begin
      if (move_val[15]) begin
        rem_l = (move_val == MOVE_MOST_NEG) ? REMAIN_MAX : neg_val[14:0];
        fwd_l = 1'b0;
      end else begin
        rem_l = move_val[14:0];
        if (move_val != 16'd0) begin
          fwd_l = 1'b1;
        end
      end
    end

    // A zero revolution length behaves as one step per revolution.
    n    = (steps_per_rev == 16'd0) ? 16'd1 : steps_per_rev;
    step = (rem_l != 15'd0) && (elapsed_t >= step_delay);

    pos_inc = {1'b0, position} + 17'd1;
    if (fwd_l) begin
      pos_step = (pos_inc >= {1'b0, n}) ? 16'd0 : pos_inc[15:0];
    end else begin
      pos_step = (position == 16'd0 || position >= n) ? n - 16'd1 : position - 16'd1;
    end

    forward_next   = fwd_l;
    position_next  = step ? pos_step : position;
    remaining_next = step ? rem_l - 15'd1 : rem_l;
    elapsed_next   = step ? 16'd0 : elapsed_t;
    coils_next     = step ? coil_pattern(four_wire, pos_step[1:0]) : coil_state;

    status.active      = (remaining != 15'd0);
    status.stepped     = step;
    status.active_next = (remaining_next != 15'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= 16'd0;
      forward    <= 1'b0;
      remaining  <= 15'd0;
      elapsed    <= ELAPSED_MAX;
      coil_state <= 4'd0;
    end else if (en) begin
      position   <= position_next;
      forward    <= forward_next;
      remaining  <= remaining_next;
      elapsed    <= elapsed_next;
      coil_state <= coils_next;
    end
  end

endmodule
`default_nettype wire

[bench/dual_stepper_move_sequencer_unit_test.sv]
// Self-checking testbench for the dual stepper move sequencer unit.
module dual_stepper_move_sequencer_unit_test;
  import dsms_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int MOTOR_Y = 0;
  localparam int MOTOR_X = 1;
  localparam logic [3:0] FOUR_WIRE_COILS [4] = '{4'h5, 4'h6, 4'hA, 4'h9};
  localparam logic [3:0] TWO_WIRE_COILS [4] = '{4'h2, 4'h3, 4'h1, 4'h0};

  typedef struct packed {
    logic        cmd;
    logic [15:0] y_move;
    logic [15:0] x_move;
  } motor_item_t;

  typedef struct packed {
    logic [3:0]  y_coils;
    logic [3:0]  x_coils;
    logic        y_stepped;
    logic        x_stepped;
    logic [15:0] y_pos;
    logic [15:0] x_pos;
    logic        busy_res;
    logic        move_refused;
  } motor_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = CMD_MOVE;
  logic signed [15:0] y_move = '0;
  logic signed [15:0] x_move = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] y_coils;
  logic [3:0] x_coils;
  logic y_stepped;
  logic x_stepped;
  logic [15:0] y_pos;
  logic [15:0] x_pos;
  logic busy_res;
  logic move_refused;

  dual_stepper_move_sequencer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .y_move       (y_move),
    .x_move       (x_move),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .y_coils      (y_coils),
    .x_coils      (x_coils),
    .y_stepped    (y_stepped),
    .x_stepped    (x_stepped),
    .y_pos        (y_pos),
    .x_pos        (x_pos),
    .busy_res     (busy_res),
    .move_refused (move_refused)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register mirror and motor state of the predictor.
  logic [15:0] rev_len [2] = '{16'd200, 16'd200};
  logic [15:0] step_gap [2] = '{16'd100, 16'd100};
  logic four_wire_mode = 1'b1;
  logic [15:0] mot_pos [2] = '{16'd0, 16'd0};
  logic mot_fwd [2] = '{1'b0, 1'b0};
  logic [14:0] mot_left [2] = '{15'd0, 15'd0};
  logic [15:0] mot_elapsed [2] = '{16'hFFFF, 16'hFFFF};
  logic [3:0] mot_coils [2] = '{4'd0, 4'd0};

  motor_item_t pending_moves [$];
  motor_result_t expected_outputs [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  logic steady = 1'b0;
  logic hold_armed = 1'b0;
  logic hold_done = 1'b0;
  int unsigned hold_left = 0;

  function automatic motor_result_t advance_motors(input motor_item_t it);
    motor_result_t res;
    logic [15:0] count [2];
    logic took [2];
    logic [16:0] mag;
    logic [16:0] span;
    logic [16:0] next_pos;
    int m;
    res = '0;
    count[MOTOR_Y] = it.y_move;
    count[MOTOR_X] = it.x_move;
    if (it.cmd == CMD_TICK) begin
      for (m = 0; m < 2; m++) begin
        if (mot_elapsed[m] != ELAPSED_MAX) mot_elapsed[m] = mot_elapsed[m] + 16'd1;
      end
    end else if (mot_left[MOTOR_Y] != 0 || mot_left[MOTOR_X] != 0) begin
      res.move_refused = 1'b1;
    end else begin
      for (m = 0; m < 2; m++) begin
        if (count[m][15]) begin
          mag = 17'h10000 - {1'b0, count[m]};
          mot_left[m] = (mag > {2'b00, REMAIN_MAX}) ? REMAIN_MAX : mag[14:0];
          mot_fwd[m] = 1'b0;
        end else begin
          mot_left[m] = count[m][14:0];
          if (count[m] != 0) mot_fwd[m] = 1'b1;
        end
      end
    end
    for (m = 0; m < 2; m++) begin
      took[m] = 1'b0;
      span = (rev_len[m] == 0) ? 17'd1 : {1'b0, rev_len[m]};
      if (mot_left[m] != 0 && mot_elapsed[m] >= step_gap[m]) begin
        if (mot_fwd[m]) begin
          next_pos = ({1'b0, mot_pos[m]} + 17'd1 >= span) ? 17'd0 : {1'b0, mot_pos[m]} + 17'd1;
        end else if (mot_pos[m] == 0 || {1'b0, mot_pos[m]} >= span) begin
          next_pos = span - 17'd1;
        end else begin
          next_pos = {1'b0, mot_pos[m]} - 17'd1;
        end
        mot_pos[m] = next_pos[15:0];
        mot_elapsed[m] = '0;
        mot_left[m] = mot_left[m] - 15'd1;
        mot_coils[m] = four_wire_mode ? FOUR_WIRE_COILS[next_pos[1:0]] :
                                        TWO_WIRE_COILS[next_pos[1:0]];
        took[m] = 1'b1;
      end
    end
    res.y_coils = mot_coils[MOTOR_Y];
    res.x_coils = mot_coils[MOTOR_X];
    res.y_stepped = took[MOTOR_Y];
    res.x_stepped = took[MOTOR_X];
    res.y_pos = mot_pos[MOTOR_Y];
    res.x_pos = mot_pos[MOTOR_X];
    res.busy_res = (mot_left[MOTOR_Y] != 0 || mot_left[MOTOR_X] != 0);
    return res;
  endfunction

  // The front of the queue is offered until its transfer, then predicted and dropped.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_outputs.push_back(advance_motors(pending_moves.pop_front()));
      end
      if (!in_valid || in_ready) begin
        if (pending_moves.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
          in_valid <= 1'b1;
          cmd <= pending_moves[0].cmd;
          y_move <= pending_moves[0].y_move;
          x_move <= pending_moves[0].x_move;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      if (mismatches < 30) $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    motor_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          if (mismatches < 30) $error("result transfer with no item outstanding");
          mismatches++;
        end else begin
          want = expected_outputs.pop_front();
          check_field("y_coils", want.y_coils, y_coils);
          check_field("x_coils", want.x_coils, x_coils);
          check_field("y_stepped", want.y_stepped, y_stepped);
          check_field("x_stepped", want.x_stepped, x_stepped);
          check_field("y_pos", want.y_pos, y_pos);
          check_field("x_pos", want.x_pos, x_pos);
          check_field("busy_res", want.busy_res, busy_res);
          check_field("move_refused", want.move_refused, move_refused);
        end
      end
      // One long hold-off lets the sender back up into the block.
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
        out_ready <= 1'b0;
        hold_left <= 120;
        hold_done <= 1'b1;
      end else begin
        out_ready <= steady || $urandom_range(99) >= 27;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_Y_STEPS_PER_REV: rev_len[MOTOR_Y] = value;
      CFG_X_STEPS_PER_REV: rev_len[MOTOR_X] = value;
      CFG_Y_STEP_DELAY:    step_gap[MOTOR_Y] = value;
      CFG_X_STEP_DELAY:    step_gap[MOTOR_X] = value;
      CFG_FOUR_WIRE:       four_wire_mode = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic push_move(input int y_count, input int x_count);
    motor_item_t it;
    it.cmd = CMD_MOVE;
    it.y_move = 16'(y_count);
    it.x_move = 16'(x_count);
    pending_moves.push_back(it);
  endtask

  // Ticks carry random payload, which the block must ignore.
  task automatic push_tick();
    motor_item_t it;
    it.cmd = CMD_TICK;
    it.y_move = 16'($urandom);
    it.x_move = 16'($urandom);
    pending_moves.push_back(it);
  endtask

  task automatic settle();
    while (pending_moves.size() != 0 || expected_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_rev_len();
    case ($urandom_range(8))
      0: return 16'd1;
      1: return 16'd2;
      2: return 16'd3;
      3: return 16'd4;
      4: return 16'd5;
      5: return 16'd200;
      6: return 16'd65535;
      default: return 16'($urandom_range(65535, 1));
    endcase
  endfunction

  // Moves with small counts, each followed by enough ticks to finish it. Some
  // streams are cut short so that the next move is refused.
  task automatic queue_random_phase(input int budget);
    int added;
    int ny;
    int nx;
    int reach;
    int ticks;
    int gap;
    int i;
    added = 0;
    while (added < budget) begin
      if ($urandom_range(9) == 0) begin
        ny = int'($urandom_range(80)) - 40;
        nx = int'($urandom_range(80)) - 40;
      end else if ($urandom_range(9) == 0) begin
        ny = 0;
        nx = 0;
      end else begin
        ny = int'($urandom_range(12)) - 6;
        nx = int'($urandom_range(12)) - 6;
      end
      push_move(ny, nx);
      added++;
      reach = (ny < 0) ? -ny : ny;
      if (nx > reach) reach = nx;
      if (-nx > reach) reach = -nx;
      // With two or more steps left the block is surely busy here.
      if (reach >= 2 && $urandom_range(3) == 0) begin
        push_move(int'($urandom_range(65535)), int'($urandom_range(65535)));
        added++;
      end
      gap = (step_gap[MOTOR_Y] > step_gap[MOTOR_X]) ? step_gap[MOTOR_Y] : step_gap[MOTOR_X];
      ticks = reach * (gap + 1) + 1;
      if ($urandom_range(4) == 0) ticks = $urandom_range(ticks);
      for (i = 0; i < ticks; i++) push_tick();
      added += ticks;
    end
  endtask

  initial begin
    int p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Largest delays: only a saturated elapsed count allows a step.
    write_reg(CFG_Y_STEPS_PER_REV, 16'd65535);
    write_reg(CFG_X_STEPS_PER_REV, 16'd1);
    write_reg(CFG_Y_STEP_DELAY, 16'hFFFF);
    write_reg(CFG_X_STEP_DELAY, 16'hFFFF);
    write_reg(CFG_FOUR_WIRE, 16'd1);
    push_tick();
    push_move(-1, 1);
    push_move(0, 0);
    push_tick();
    settle();

    // Y sits beyond a shorter revolution; X has zero steps per revolution.
    write_reg(CFG_Y_STEPS_PER_REV, 16'd200);
    write_reg(CFG_X_STEPS_PER_REV, 16'd0);
    write_reg(CFG_Y_STEP_DELAY, 16'd0);
    write_reg(CFG_X_STEP_DELAY, 16'd2);
    write_reg(CFG_FOUR_WIRE, 16'd0);
    push_move(3, -3);
    push_move(0, 0);
    push_move(-32767, 32767);
    repeat (8) push_tick();
    settle();

    // Coil mode changes take effect only at the next step.
    write_reg(CFG_Y_STEPS_PER_REV, 16'd2);
    write_reg(CFG_X_STEPS_PER_REV, 16'd3);
    write_reg(CFG_X_STEP_DELAY, 16'd0);
    write_reg(CFG_FOUR_WIRE, 16'd1);
    push_tick();
    push_move(-1, -2);
    repeat (3) push_tick();
    push_move(0, 0);
    push_move(0, -1);
    repeat (2) push_tick();
    settle();

    for (p = 0; p < 5; p++) begin
      write_reg(CFG_Y_STEPS_PER_REV, pick_rev_len());
      write_reg(CFG_X_STEPS_PER_REV, pick_rev_len());
      write_reg(CFG_Y_STEP_DELAY, 16'($urandom_range(3)));
      write_reg(CFG_X_STEP_DELAY, 16'($urandom_range(3)));
      write_reg(CFG_FOUR_WIRE, 16'($urandom_range(1)));
      steady <= (p == 3);
      if (p == 1) hold_armed <= 1'b1;
      queue_random_phase(120);
      settle();
    end
    steady <= 1'b0;

    // The most negative count saturates to 32767 backward steps, so the block
    // stays busy and the closing move is refused.
    write_reg(CFG_Y_STEPS_PER_REV, 16'd7);
    write_reg(CFG_X_STEPS_PER_REV, 16'd65535);
    write_reg(CFG_Y_STEP_DELAY, 16'd0);
    write_reg(CFG_X_STEP_DELAY, 16'd0);
    push_move(-32768, 32767);
    repeat (20) push_tick();
    push_move(0, 0);
    settle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
